// ===== rtl/core/udiv_pkg.sv =====
`timescale 1ns / 1ps

package udiv_pkg;

    // operand half width and derived sizes
    localparam int HALF_WIDTH = 64;
    localparam int FULL_WIDTH = 2 * HALF_WIDTH;
    localparam int CNT_W      = $clog2(FULL_WIDTH);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FULL_WIDTH - 1);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } udiv_state_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic load;
        logic step;
    } udiv_ctl_t;

endpackage

// ===== rtl/core/udiv_datapath.sv =====
`timescale 1ns / 1ps

module udiv_datapath
    import udiv_pkg::*;
(
    input  logic                  clk,
    input  udiv_ctl_t             ctl,
    input  logic [FULL_WIDTH-1:0] dividend,
    input  logic [FULL_WIDTH-1:0] divisor,
    output logic                  in_zero,
    output logic [FULL_WIDTH-1:0] quo,
    output logic [FULL_WIDTH-1:0] rem,
    output logic                  zero_flag
);

    // quo_reg holds unconsumed dividend bits at the top, quotient bits shift in at the bottom
    logic [FULL_WIDTH-1:0] rem_reg, rem_next;
    logic [FULL_WIDTH-1:0] quo_reg, quo_next;
    logic [FULL_WIDTH-1:0] dvs_reg;
    logic                  zero_reg, zero_next;

    logic [FULL_WIDTH:0]   shifted;
    logic [FULL_WIDTH:0]   diff;
    logic                  ge;

    assign in_zero = (divisor == '0);

    // shared shift / compare / subtract unit
    always_comb
    begin
        shifted = {rem_reg, quo_reg[FULL_WIDTH-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    // next register values
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        zero_next = zero_reg;
        if (ctl.load)
        begin
            zero_next = in_zero;
            if (in_zero)
            begin
                rem_next = dividend;
                quo_next = '1;
            end
            else
            begin
                rem_next = '0;
                quo_next = dividend;
            end
        end
        else if (ctl.step)
        begin
            rem_next = ge ? diff[FULL_WIDTH-1:0] : shifted[FULL_WIDTH-1:0];
            quo_next = {quo_reg[FULL_WIDTH-2:0], ge};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
        if (ctl.load)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign zero_flag = zero_reg;

endmodule

// ===== rtl/core/udiv_ctrl.sv =====
`timescale 1ns / 1ps

module udiv_ctrl
    import udiv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      in_zero,
    input  logic      done_take,
    output logic      done,
    output udiv_ctl_t ctl
);

    udiv_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        done       = 1'b0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = LAST_STEP;
                    state_next = in_zero ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                ctl.step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
                if (done_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // load with a nonzero divisor starts the bit loop at the top step
    a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && !in_zero) |=> (state_reg == S_RUN && cnt_reg == LAST_STEP))
        else $error("load did not start the bit loop");

    // zero divisor skips the loop
    a_zero_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && in_zero) |=> (state_reg == S_DONE))
        else $error("zero divisor did not finish at once");

    // last step hands over to done
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && cnt_reg == '0) |=> (state_reg == S_DONE))
        else $error("bit loop overran");

    // datapath never loads and steps together
    a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.step))
        else $error("load and step together");

endmodule

// ===== rtl/core/udiv128_quotient_remainder_unit.sv =====
`timescale 1ns / 1ps
// sequencing: after the input accept a nonzero divisor runs 128 subtract steps and
//   then hands the result to the output register; a zero divisor skips the steps
// a new word is accepted only after the last result reaches the output register,
//   and the single 129-bit subtractor makes one quotient bit per cycle
// reset: rst_n asynchronous active low clears sequencer and output valid

module udiv128_quotient_remainder_unit
    import udiv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [HALF_WIDTH-1:0] dividend_hi,
    input  logic [HALF_WIDTH-1:0] dividend_lo,
    input  logic [HALF_WIDTH-1:0] divisor_hi,
    input  logic [HALF_WIDTH-1:0] divisor_lo,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [HALF_WIDTH-1:0] quotient_hi,
    output logic [HALF_WIDTH-1:0] quotient_lo,
    output logic [HALF_WIDTH-1:0] remainder_hi,
    output logic [HALF_WIDTH-1:0] remainder_lo,
    output logic                  divide_by_zero
);

    udiv_ctl_t             ctl;
    logic                  in_zero;
    logic                  done;
    logic                  done_take;
    logic [FULL_WIDTH-1:0] quo;
    logic [FULL_WIDTH-1:0] rem;
    logic                  zero_flag;

    logic                  out_valid_reg, out_valid_next;
    logic [FULL_WIDTH-1:0] quo_out_reg;
    logic [FULL_WIDTH-1:0] rem_out_reg;
    logic                  dbz_out_reg;

    udiv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_zero   (in_zero),
        .done_take (done_take),
        .done      (done),
        .ctl       (ctl)
    );

    udiv_datapath u_datapath (
        .clk       (clk),
        .ctl       (ctl),
        .dividend  ({dividend_hi, dividend_lo}),
        .divisor   ({divisor_hi, divisor_lo}),
        .in_zero   (in_zero),
        .quo       (quo),
        .rem       (rem),
        .zero_flag (zero_flag)
    );

    // output word register, refilled when empty or being taken
    assign done_take = done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            quo_out_reg <= quo;
            rem_out_reg <= rem;
            dbz_out_reg <= zero_flag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quotient_hi    = quo_out_reg[FULL_WIDTH-1:HALF_WIDTH];
    assign quotient_lo    = quo_out_reg[HALF_WIDTH-1:0];
    assign remainder_hi   = rem_out_reg[FULL_WIDTH-1:HALF_WIDTH];
    assign remainder_lo   = rem_out_reg[HALF_WIDTH-1:0];
    assign divide_by_zero = dbz_out_reg;

    // zero divisor word carries an all-ones quotient
    a_dbz_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dbz_out_reg) |-> (quo_out_reg == '1))
        else $error("divide by zero word without all-ones quotient");

    // a finished result is only moved while the core is busy
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_take |-> in_stall)
        else $error("result handoff while core idle");

    // a held output word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !done_take)
        else $error("output word overwritten while stalled");

endmodule
